@@ rtl/core/tta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_pkg
// Shared types, operation codes and saturation helper for the truncated
// Taylor series arithmetic block.
// ----------------------------------------------------------------------------
package tta_pkg;

    localparam int COEFF_W = 32;

    typedef logic [2:0] t_mode;

    localparam t_mode MODE_ADD = 3'd0;
    localparam t_mode MODE_SUB = 3'd1;
    localparam t_mode MODE_NEG = 3'd2;
    localparam t_mode MODE_MUL = 3'd3;
    localparam t_mode MODE_DIV = 3'd4;

    localparam logic signed [COEFF_W-1:0] COEFF_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
    localparam logic signed [COEFF_W-1:0] COEFF_MIN = {1'b1, {(COEFF_W-1){1'b0}}};

    // one product term handed to the shared multiply-accumulate unit
    typedef struct packed {
        logic vld;
        logic sub;
    } t_mac_term;

    function automatic logic signed [COEFF_W-1:0] f_sat32(input logic signed [63:0] x);
        logic signed [COEFF_W-1:0] res;
        if (x > 64'(COEFF_MAX)) begin
            res = COEFF_MAX;
        end else if (x < 64'(COEFF_MIN)) begin
            res = COEFF_MIN;
        end else begin
            res = x[COEFF_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/tta_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_mac
// Shared multiply-accumulate unit: registered 32x32 product, then floor
// shift, saturation and add or subtract into a wide accumulator.
// ----------------------------------------------------------------------------
module tta_mac #(
    parameter int FRAC_BITS = 16,
    parameter int ACC_W     = 36
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clear,
    input  logic signed [ACC_W-1:0]             i_init,
    input  tta_pkg::t_mac_term                  i_term,
    input  logic signed [tta_pkg::COEFF_W-1:0]  i_x,
    input  logic signed [tta_pkg::COEFF_W-1:0]  i_y,
    output logic signed [ACC_W-1:0]             o_acc,
    output logic                                o_idle
);
    import tta_pkg::*;

    logic                        r_prod_vld;
    logic                        r_prod_sub;
    logic signed [63:0]          r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [COEFF_W-1:0]   w_term;

    // arithmetic shift right is the floor of the scaled product
    assign w_term = f_sat32(r_prod >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_prod_sub <= 1'b0;
        end else begin
            r_prod_vld <= i_term.vld;
            r_prod_sub <= i_term.sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_x) * 64'(i_y);
        if (i_clear) begin
            r_acc <= i_init;
        end else if (r_prod_vld) begin
            if (r_prod_sub) begin
                r_acc <= r_acc - ACC_W'(w_term);
            end else begin
                r_acc <= r_acc + ACC_W'(w_term);
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_idle = !r_prod_vld;

endmodule

@@ rtl/core/tta_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tta_div
// Radix-2 restoring divider: (s << FRAC_BITS) / d, truncated toward zero
// and saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module tta_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [tta_pkg::COEFF_W-1:0]  i_dividend,
    input  logic signed [tta_pkg::COEFF_W-1:0]  i_divisor,
    output logic                                o_done,
    output logic signed [tta_pkg::COEFF_W-1:0]  o_quot
);
    import tta_pkg::*;

    localparam int NUM_W = COEFF_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [NUM_W-1:0]      r_sh;
    logic [COEFF_W-1:0]    r_rem;
    logic [COEFF_W-1:0]    r_dmag;
    logic                  r_neg;

    logic [COEFF_W-1:0]    w_s_mag;
    logic [COEFF_W-1:0]    w_d_mag;
    logic [COEFF_W:0]      w_rem_sh;
    logic [COEFF_W:0]      w_rem_sub;
    logic                  w_ge;
    logic                  w_too_big;

    assign w_s_mag   = i_dividend[COEFF_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_d_mag   = i_divisor[COEFF_W-1]  ? (~i_divisor + 1'b1)  : i_divisor;
    assign w_rem_sh  = {r_rem, r_sh[NUM_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_dmag};
    assign w_ge      = (w_rem_sh >= {1'b0, r_dmag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh   <= NUM_W'(w_s_mag) << FRAC_BITS;
            r_rem  <= '0;
            r_dmag <= w_d_mag;
            r_neg  <= i_dividend[COEFF_W-1] ^ i_divisor[COEFF_W-1];
        end else if (r_busy) begin
            // dividend bits shift out the top, quotient bits shift in below
            r_sh  <= {r_sh[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[COEFF_W-1:0] : w_rem_sh[COEFF_W-1:0];
        end
    end

    // negative side may reach 2^31, positive side only 2^31 - 1
    always_comb begin
        if (r_neg) begin
            w_too_big = (|r_sh[NUM_W-1:COEFF_W]) ||
                        (r_sh[COEFF_W-1] && (|r_sh[COEFF_W-2:0]));
            o_quot    = w_too_big ? COEFF_MIN : (~r_sh[COEFF_W-1:0] + 1'b1);
        end else begin
            w_too_big = |r_sh[NUM_W-1:COEFF_W-1];
            o_quot    = w_too_big ? COEFF_MAX : r_sh[COEFF_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

@@ rtl/core/truncated_taylor_arith.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// truncated_taylor_arith
// Add, sub, neg, Cauchy product and series division of truncated Taylor
// coefficient vectors, one coefficient pair per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries coefficient n of a and b,
//   lowest index first; i_start_req marks coefficient 0 and latches i_mode.
//   Output channel (o_out_valid / i_out_stall) returns result coefficient n,
//   o_last at n == min(series_order, MAX_ORDER), o_div_zero for div with b0=0.
//   i_cfg_we writes series_order; write it only while the block is idle.
// Sequencing, accept to result valid:
//   add/sub/neg: result registered, then moved to the output register.  mul: n+1 terms through the MAC.
//   div: n terms through the MAC (none at n = 0), then the bit-serial divider
//   when b0 != 0.
//   One request is in work at a time, stepped by the sequencer through the
//   single MAC and the bit-serial divider.
// Stall: a finished result waits in the output register; the next request is
//   accepted and worked meanwhile and parks until the output register frees.
// Reset: synchronous, clears index, latched mode (add), zero-divisor flag and
//   sets series_order to 1. Coefficient stores need no clearing.
// ----------------------------------------------------------------------------
module truncated_taylor_arith #(
    parameter int MAX_ORDER = 7,
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [2:0]                          i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tta_pkg::t_mode                      i_mode,
    input  logic                                i_start_req,
    input  logic signed [tta_pkg::COEFF_W-1:0]  i_a_coeff,
    input  logic signed [tta_pkg::COEFF_W-1:0]  i_b_coeff,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [tta_pkg::COEFF_W-1:0]  o_r_coeff,
    output logic                                o_last,
    output logic                                o_div_zero
);
    import tta_pkg::*;

    localparam int DEPTH = MAX_ORDER + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OW    = (IDX_W > 3) ? IDX_W : 3;
    localparam int ACC_W = COEFF_W + IDX_W + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                    r_state, n_state;
    logic [2:0]                r_series_order;
    logic [IDX_W-1:0]          r_idx;
    t_mode                     r_mode;
    logic                      r_zdiv;
    logic signed [COEFF_W-1:0] r_b0;
    logic [IDX_W-1:0]          r_n;
    logic [IDX_W-1:0]          r_cnt;
    logic signed [COEFF_W-1:0] r_res;
    logic                      r_q_vld;
    logic signed [COEFF_W-1:0] r_a_q;
    logic signed [COEFF_W-1:0] r_b_q;
    logic signed [COEFF_W-1:0] r_r_q;
    logic                      r_out_vld;
    logic signed [COEFF_W-1:0] r_out_coeff;
    logic                      r_out_last;
    logic                      r_out_dz;

    logic signed [COEFF_W-1:0] a_mem [DEPTH];
    logic signed [COEFF_W-1:0] b_mem [DEPTH];
    logic signed [COEFF_W-1:0] r_mem [DEPTH];

    logic [OW-1:0]             w_cfg_ext;
    logic [IDX_W-1:0]          w_ord;
    logic                      w_in_acc;
    t_mode                     w_mode;
    logic [IDX_W-1:0]          w_n;
    logic signed [COEFF_W-1:0] w_simple;
    logic                      w_drained;
    logic                      w_out_free;
    logic                      w_last;
    logic signed [ACC_W-1:0]   w_acc;
    logic                      w_mac_idle;
    logic signed [COEFF_W-1:0] w_s;
    logic signed [COEFF_W-1:0] w_zsat;
    logic                      w_div_start;
    logic                      w_div_done;
    logic signed [COEFF_W-1:0] w_quot;
    logic                      w_is_mul;
    logic                      w_is_div;
    logic [IDX_W-1:0]          w_rev;
    t_mac_term                 w_term;

    assign w_cfg_ext = OW'(r_series_order);
    assign w_ord     = (w_cfg_ext < OW'(MAX_ORDER)) ? IDX_W'(w_cfg_ext) : IDX_W'(MAX_ORDER);

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_mode     = i_start_req ? i_mode : r_mode;
    // a start or an index past the current order opens a new vector
    assign w_n        = (i_start_req || (r_idx > w_ord)) ? '0 : r_idx;

    assign w_is_mul   = (r_mode == MODE_MUL);
    assign w_is_div   = (r_mode == MODE_DIV);
    assign w_rev      = r_n - r_cnt;
    assign w_last     = (r_n == w_ord);
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_drained  = !r_q_vld && w_mac_idle;

    assign w_s    = f_sat32(64'(w_acc));
    assign w_zsat = w_s[COEFF_W-1] ? COEFF_MIN : ((|w_s) ? COEFF_MAX : '0);

    assign w_div_start = (r_state == S_DRAIN) && w_drained && w_is_div && !r_zdiv;

    always_comb begin
        case (w_mode)
            MODE_SUB: w_simple = f_sat32(64'(i_a_coeff) - 64'(i_b_coeff));
            MODE_NEG: w_simple = f_sat32(-64'(i_a_coeff));
            default:  w_simple = f_sat32(64'(i_a_coeff) + 64'(i_b_coeff));
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_mode == MODE_MUL) begin
                        n_state = S_ISSUE;
                    end else if (w_mode == MODE_DIV) begin
                        n_state = (w_n == '0) ? S_DRAIN : S_ISSUE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ISSUE: begin
                if (r_cnt == r_n) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_drained) begin
                    n_state = w_div_start ? S_DIV : S_DONE;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_series_order <= 3'd1;
            r_idx          <= '0;
            r_mode         <= MODE_ADD;
            r_zdiv         <= 1'b0;
            r_q_vld        <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_q_vld <= (r_state == S_ISSUE);
            if (i_cfg_we) begin
                r_series_order <= i_cfg_wdata;
            end
            if (w_in_acc) begin
                r_mode <= w_mode;
                if (w_n == '0) begin
                    r_zdiv <= (w_mode == MODE_DIV) && (i_b_coeff == '0);
                end
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_vld <= 1'b1;
                r_idx     <= w_last ? '0 : r_n + 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // sequencer payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_n <= w_n;
            if (w_n == '0) begin
                r_b0 <= i_b_coeff;
            end
            // div skips the i = 0 term, it is the b0 divide itself
            r_cnt <= (w_mode == MODE_DIV) ? IDX_W'(1) : '0;
            r_res <= w_simple;
        end else if (r_state == S_ISSUE) begin
            r_cnt <= r_cnt + 1'b1;
        end else if ((r_state == S_DRAIN) && w_drained) begin
            r_res <= (w_is_div && r_zdiv) ? w_zsat : w_s;
        end else if ((r_state == S_DIV) && w_div_done) begin
            r_res <= w_quot;
        end

        if ((r_state == S_DONE) && w_out_free) begin
            r_out_coeff <= r_res;
            r_out_last  <= w_last;
            r_out_dz    <= w_is_div && r_zdiv;
        end
    end

    // coefficient stores
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            a_mem[w_n] <= i_a_coeff;
            b_mem[w_n] <= i_b_coeff;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_mem[r_n] <= r_res;
        end
        if (r_state == S_ISSUE) begin
            r_a_q <= a_mem[r_cnt];
            r_b_q <= b_mem[w_is_mul ? w_rev : r_cnt];
            r_r_q <= r_mem[w_rev];
        end
    end

    assign w_term.vld = r_q_vld;
    assign w_term.sub = w_is_div;

    tta_mac #(
        .FRAC_BITS (FRAC_BITS),
        .ACC_W     (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_in_acc),
        .i_init  ((w_mode == MODE_DIV) ? ACC_W'(i_a_coeff) : '0),
        .i_term  (w_term),
        .i_x     (w_is_mul ? r_a_q : r_r_q),
        .i_y     (r_b_q),
        .o_acc   (w_acc),
        .o_idle  (w_mac_idle)
    );

    tta_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_s),
        .i_divisor  (r_b0),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign o_out_valid = r_out_vld;
    assign o_r_coeff   = r_out_coeff;
    assign o_last      = r_out_last;
    assign o_div_zero  = r_out_dz;

    a_acc_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state != S_IDLE))
        else $error("accepted request did not start the sequencer");

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> (r_cnt <= r_n))
        else $error("term counter ran past the coefficient index");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_DONE))
        else $error("result presented without finishing the sequence");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

endmodule
